// ===== rtl/hwli_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hwli_pkg
// Types and constants shared by the humidifier water-loss interlock.
// ----------------------------------------------------------------------------
package hwli_pkg;

    typedef enum logic [2:0] {
        ST_NORMAL    = 3'd0,
        ST_RESERVE   = 3'd1,
        ST_PULSE_ON  = 3'd2,
        ST_PULSE_OFF = 3'd3,
        ST_LOCKED    = 3'd4
    } policy_state_t;

    // register indexes on the configuration port
    typedef enum logic [2:0] {
        REG_RESERVE_SECONDS   = 3'd0,
        REG_PULSE_ON_SECONDS  = 3'd1,
        REG_PULSE_OFF_SECONDS = 3'd2,
        REG_RISE_THRESHOLD    = 3'd3,
        REG_FLAT_LIMIT        = 3'd4
    } reg_index_t;

    localparam int unsigned SEC_W  = 16;
    localparam int unsigned MS_W   = 26;
    localparam int unsigned RH_W   = 14;
    localparam int unsigned FLAT_W = 8;

    localparam logic [MS_W-1:0]   MS_PER_SEC = MS_W'(1000);
    localparam logic [RH_W-1:0]   RH_FULL    = RH_W'(10000);
    localparam logic [FLAT_W-1:0] FLAT_MAX   = '1;

    localparam logic [SEC_W-1:0]  RESERVE_SECONDS_RST   = SEC_W'(600);
    localparam logic [SEC_W-1:0]  PULSE_ON_SECONDS_RST  = SEC_W'(60);
    localparam logic [SEC_W-1:0]  PULSE_OFF_SECONDS_RST = SEC_W'(120);
    localparam logic [MS_W-1:0]   RESERVE_MS_RST        = MS_W'(600000);
    localparam logic [MS_W-1:0]   PULSE_ON_MS_RST       = MS_W'(60000);
    localparam logic [MS_W-1:0]   PULSE_OFF_MS_RST      = MS_W'(120000);
    localparam logic [RH_W-1:0]   RISE_THRESHOLD_RST    = RH_W'(100);
    localparam logic [FLAT_W-1:0] FLAT_LIMIT_RST        = FLAT_W'(3);

    typedef struct packed {
        policy_state_t     state;
        logic [31:0]       reserve_start;
        logic [31:0]       phase_start;
        logic [RH_W-1:0]   baseline;
        logic [FLAT_W-1:0] flat_count;
    } policy_t;

    // window lengths already scaled to milliseconds, rise threshold and flat limit
    typedef struct packed {
        logic [MS_W-1:0]   reserve_ms;
        logic [MS_W-1:0]   pulse_on_ms;
        logic [MS_W-1:0]   pulse_off_ms;
        logic [RH_W-1:0]   rise_threshold;
        logic [FLAT_W-1:0] flat_limit;
    } cfg_t;

endpackage
`default_nettype wire

// ===== rtl/hwli_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hwli_core
// Next-state and drive gating logic for one policy step.
// ----------------------------------------------------------------------------
module hwli_core
    import hwli_pkg::*;
(
    input  wire policy_t          cur,
    input  wire cfg_t             cfg,
    input  wire logic             mode,
    input  wire logic             water_present,
    input  wire logic [31:0]      now_ms,
    input  wire logic [RH_W-1:0]  requested_drive,
    input  wire logic [RH_W-1:0]  humidity,
    input  wire logic             humidity_ok,
    output policy_t               nxt,
    output logic [RH_W-1:0]       drive
);

    logic [31:0]       start_ms;
    logic [MS_W-1:0]   limit_ms;
    logic [31:0]       elapsed;
    logic              expired;
    logic              hum_valid;
    logic [RH_W-1:0]   base_new;
    logic [FLAT_W-1:0] flat_inc;
    logic [RH_W:0]     rise_target;
    logic              rise_ok;
    logic [FLAT_W-1:0] flat_after;

    always_comb
    begin
        start_ms = (cur.state == ST_RESERVE) ? cur.reserve_start : cur.phase_start;
        case (cur.state)
            ST_RESERVE:   limit_ms = cfg.reserve_ms;
            ST_PULSE_ON:  limit_ms = cfg.pulse_on_ms;
            default:      limit_ms = cfg.pulse_off_ms;
        endcase
        elapsed     = now_ms - start_ms;
        expired     = elapsed >= 32'(limit_ms);
        hum_valid   = humidity_ok && (humidity <= RH_FULL);
        base_new    = hum_valid ? humidity : '0;
        flat_inc    = (cur.flat_count == FLAT_MAX) ? cur.flat_count
                                                   : cur.flat_count + FLAT_W'(1);
        rise_target = {1'b0, cur.baseline} + {1'b0, cfg.rise_threshold};
        rise_ok     = hum_valid && (cur.baseline != '0)
                      && ({1'b0, humidity} >= rise_target);
        flat_after  = rise_ok ? '0 : flat_inc;
    end

    always_comb
    begin
        nxt   = cur;
        drive = requested_drive;
        if (mode)
        begin
            nxt.state         = ST_NORMAL;
            nxt.reserve_start = '0;
            nxt.phase_start   = '0;
            nxt.baseline      = '0;
            nxt.flat_count    = '0;
            drive             = '0;
        end
        else
        begin
            case (cur.state)
                ST_NORMAL:
                begin
                    if (!water_present)
                    begin
                        nxt.reserve_start = now_ms;
                        nxt.state         = ST_RESERVE;
                    end
                end
                ST_RESERVE:
                begin
                    if (water_present)
                        nxt.state = ST_NORMAL;
                    else if (expired)
                    begin
                        nxt.phase_start = now_ms;
                        nxt.baseline    = base_new;
                        nxt.flat_count  = '0;
                        nxt.state       = ST_PULSE_ON;
                    end
                end
                ST_PULSE_ON:
                begin
                    if (water_present)
                        nxt.state = ST_NORMAL;
                    else if (expired)
                    begin
                        nxt.flat_count = flat_after;
                        drive          = '0;
                        if (flat_after >= cfg.flat_limit)
                            nxt.state = ST_LOCKED;
                        else
                        begin
                            nxt.phase_start = now_ms;
                            nxt.state       = ST_PULSE_OFF;
                        end
                    end
                end
                ST_PULSE_OFF:
                begin
                    if (water_present)
                        nxt.state = ST_NORMAL;
                    else if (expired)
                    begin
                        nxt.phase_start = now_ms;
                        nxt.baseline    = base_new;
                        nxt.state       = ST_PULSE_ON;
                    end
                    else
                        drive = '0;
                end
                ST_LOCKED:
                    drive = '0;
                default:
                    nxt = cur;
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== rtl/humidifier_water_loss_interlock.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// humidifier_water_loss_interlock
// Gates a humidifier drive on water presence: reserve window, on/off pulsing
// with a flat-humidity check, and a sticky lock.
//
//   channel  direction  handshake            payload
//   in       sink       in_valid/in_ready    mode, water_present, now_ms,
//                                            requested_drive, humidity,
//                                            humidity_ok
//   out      source     out_valid/out_ready  drive_out, policy_code, locked
//   cfg      apb slave  psel/penable/pready  paddr, pwdata, prdata
//
// one transfer per cycle in each direction while out_ready does not stall the
// result; each input passes through the input register, then the result
// register, before its result transfer
// policy state advances when the input register moves into the result register
// a stalled result holds the result register; the input register still takes
// one more transfer, then in_ready drops
// rst_n clears all policy state and restores register defaults
// ----------------------------------------------------------------------------
module humidifier_water_loss_interlock
    import hwli_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic              mode,
    input  wire logic              water_present,
    input  wire logic [31:0]       now_ms,
    input  wire logic [RH_W-1:0]   requested_drive,
    input  wire logic [RH_W-1:0]   humidity,
    input  wire logic              humidity_ok,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [RH_W-1:0]        drive_out,
    output logic [2:0]             policy_code,
    output logic                   locked,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [4:0]        paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    logic [SEC_W-1:0]  reserve_seconds_reg;
    logic [SEC_W-1:0]  pulse_on_seconds_reg;
    logic [SEC_W-1:0]  pulse_off_seconds_reg;
    cfg_t              cfg_reg;
    logic              cfg_write;
    reg_index_t        cfg_index;
    logic [MS_W-1:0]   wdata_ms;

    logic              s1_valid_reg;
    logic              s1_mode_reg;
    logic              s1_water_reg;
    logic [31:0]       s1_now_reg;
    logic [RH_W-1:0]   s1_req_reg;
    logic [RH_W-1:0]   s1_hum_reg;
    logic              s1_hum_ok_reg;
    logic              advance;
    logic              in_xfer;

    policy_t           policy_reg;
    policy_t           policy_next;
    logic [RH_W-1:0]   drive_next;

    logic              out_valid_reg;
    logic [RH_W-1:0]   drive_out_reg;
    policy_state_t     code_reg;

    // configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_index = reg_index_t'(paddr[4:2]);
    assign wdata_ms  = MS_W'(pwdata[SEC_W-1:0]) * MS_PER_SEC;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reserve_seconds_reg   <= RESERVE_SECONDS_RST;
            pulse_on_seconds_reg  <= PULSE_ON_SECONDS_RST;
            pulse_off_seconds_reg <= PULSE_OFF_SECONDS_RST;
            cfg_reg.reserve_ms    <= RESERVE_MS_RST;
            cfg_reg.pulse_on_ms   <= PULSE_ON_MS_RST;
            cfg_reg.pulse_off_ms  <= PULSE_OFF_MS_RST;
            cfg_reg.rise_threshold <= RISE_THRESHOLD_RST;
            cfg_reg.flat_limit    <= FLAT_LIMIT_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_RESERVE_SECONDS:
                begin
                    reserve_seconds_reg <= pwdata[SEC_W-1:0];
                    cfg_reg.reserve_ms  <= wdata_ms;
                end
                REG_PULSE_ON_SECONDS:
                begin
                    pulse_on_seconds_reg <= pwdata[SEC_W-1:0];
                    cfg_reg.pulse_on_ms  <= wdata_ms;
                end
                REG_PULSE_OFF_SECONDS:
                begin
                    pulse_off_seconds_reg <= pwdata[SEC_W-1:0];
                    cfg_reg.pulse_off_ms  <= wdata_ms;
                end
                REG_RISE_THRESHOLD: cfg_reg.rise_threshold <= pwdata[RH_W-1:0];
                REG_FLAT_LIMIT:     cfg_reg.flat_limit     <= pwdata[FLAT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_index)
            REG_RESERVE_SECONDS:   prdata = 32'(reserve_seconds_reg);
            REG_PULSE_ON_SECONDS:  prdata = 32'(pulse_on_seconds_reg);
            REG_PULSE_OFF_SECONDS: prdata = 32'(pulse_off_seconds_reg);
            REG_RISE_THRESHOLD:    prdata = 32'(cfg_reg.rise_threshold);
            REG_FLAT_LIMIT:        prdata = 32'(cfg_reg.flat_limit);
            default:               prdata = '0;
        endcase
    end

    // input register
    assign advance  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || advance;
    assign in_xfer  = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_xfer)
            s1_valid_reg <= 1'b1;
        else if (advance)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_mode_reg   <= mode;
            s1_water_reg  <= water_present;
            s1_now_reg    <= now_ms;
            s1_req_reg    <= requested_drive;
            s1_hum_reg    <= humidity;
            s1_hum_ok_reg <= humidity_ok;
        end
    end

    hwli_core u_core (
        .cur             (policy_reg),
        .cfg             (cfg_reg),
        .mode            (s1_mode_reg),
        .water_present   (s1_water_reg),
        .now_ms          (s1_now_reg),
        .requested_drive (s1_req_reg),
        .humidity        (s1_hum_reg),
        .humidity_ok     (s1_hum_ok_reg),
        .nxt             (policy_next),
        .drive           (drive_next)
    );

    // policy state and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg.state         <= ST_NORMAL;
            policy_reg.reserve_start <= '0;
            policy_reg.phase_start   <= '0;
            policy_reg.baseline      <= '0;
            policy_reg.flat_count    <= '0;
            out_valid_reg            <= 1'b0;
        end
        else if (advance)
        begin
            policy_reg    <= policy_next;
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            drive_out_reg <= drive_next;
            code_reg      <= policy_next.state;
        end
    end

    assign out_valid   = out_valid_reg;
    assign drive_out   = drive_out_reg;
    assign policy_code = code_reg;
    assign locked      = (code_reg == ST_LOCKED);

endmodule
`default_nettype wire

// ===== rtl/hwli_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hwli_checker
// Port-level checks for the humidifier water-loss interlock, bound to the top.
// ----------------------------------------------------------------------------
module hwli_checker
    import hwli_pkg::*;
(
    input wire logic            clk,
    input wire logic            rst_n,
    input wire logic            in_valid,
    input wire logic            in_ready,
    input wire logic            out_valid,
    input wire logic            out_ready,
    input wire logic [RH_W-1:0] drive_out,
    input wire logic [2:0]      policy_code,
    input wire logic            locked
);

    // lock flag agrees with the reported state
    a_lock_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (locked == (policy_code == ST_LOCKED)))
        else $error("locked flag disagrees with policy_code");

    // a locked result never drives the humidifier
    a_lock_drive: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && locked) |-> (drive_out == '0))
        else $error("drive_out nonzero while locked");

    // only defined state codes appear
    a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (policy_code <= ST_LOCKED))
        else $error("policy_code out of range");

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
            (out_valid && $stable(drive_out) && $stable(policy_code)))
        else $error("result changed while stalled");

    // input side never blocks after the result register was empty and no input was offered
    a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (!out_valid && !in_valid) |=> in_ready)
        else $error("in_ready low with empty pipeline");

endmodule

bind humidifier_water_loss_interlock hwli_checker u_hwli_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .drive_out   (drive_out),
    .policy_code (policy_code),
    .locked      (locked)
);
`default_nettype wire

// ===== test/humidifier_water_loss_interlock_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// humidifier_water_loss_interlock_checker
// Watches the input, result and register ports of the water-loss interlock,
// runs its own copy of the drive gating policy on every input transfer and
// compares each result transfer against the oldest predicted drive, state
// and lock flag.
// ----------------------------------------------------------------------------
module humidifier_water_loss_interlock_checker
    import hwli_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_ready,
    input  logic              mode,
    input  logic              water_present,
    input  logic [31:0]       now_ms,
    input  logic [RH_W-1:0]   requested_drive,
    input  logic [RH_W-1:0]   humidity,
    input  logic              humidity_ok,
    input  logic              out_valid,
    input  logic              out_ready,
    input  logic [RH_W-1:0]   drive_out,
    input  logic [2:0]        policy_code,
    input  logic              locked,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [4:0]        paddr,
    input  logic [31:0]       pwdata,
    input  logic              pready,
    output int                pending,
    output int                errors,
    output int                checked,
    output int                lock_hits
);

    typedef struct packed {
        logic [RH_W-1:0] drive;
        policy_state_t   code;
        logic            lock;
    } gated_drive_t;

    localparam logic [31:0] MS_IN_SEC = 32'd1000;

    logic [SEC_W-1:0]  reserve_s;
    logic [SEC_W-1:0]  on_s;
    logic [SEC_W-1:0]  off_s;
    logic [RH_W-1:0]   rise_min;
    logic [FLAT_W-1:0] flat_lim;
    policy_state_t     pol_state;
    logic [31:0]       reserve_t0;
    logic [31:0]       window_t0;
    logic [RH_W-1:0]   base_rh;
    logic [FLAT_W-1:0] flat_run;
    gated_drive_t      awaited_drives[$];
    int                n_err;
    int                n_checked;
    int                n_lock;

    function automatic logic [31:0] to_ms(input logic [SEC_W-1:0] secs);
        return 32'(secs) * MS_IN_SEC;
    endfunction

    function automatic void back_to_normal();
        pol_state  = ST_NORMAL;
        reserve_t0 = '0;
        window_t0  = '0;
        base_rh    = '0;
        flat_run   = '0;
    endfunction

    function automatic void count_flat();
        if (flat_run != FLAT_MAX)
        begin
            flat_run++;
        end
    endfunction

    function automatic gated_drive_t gate_drive(
        input logic            md,
        input logic            wet,
        input logic [31:0]     now,
        input logic [RH_W-1:0] req,
        input logic [RH_W-1:0] hum,
        input logic            hum_ok
    );
        logic            hum_good;
        logic [RH_W-1:0] drive;
        gated_drive_t    res;
        hum_good = hum_ok && (hum <= RH_FULL);
        drive    = req;
        if (md)
        begin
            back_to_normal();
            drive = '0;
        end
        else
        begin
            case (pol_state)
                ST_NORMAL:
                begin
                    if (!wet)
                    begin
                        reserve_t0 = now;
                        pol_state  = ST_RESERVE;
                    end
                end
                ST_RESERVE:
                begin
                    if (wet)
                    begin
                        pol_state = ST_NORMAL;
                    end
                    else if (now - reserve_t0 >= to_ms(reserve_s))
                    begin
                        window_t0 = now;
                        base_rh   = hum_good ? hum : '0;
                        flat_run  = '0;
                        pol_state = ST_PULSE_ON;
                    end
                end
                ST_PULSE_ON:
                begin
                    if (wet)
                    begin
                        pol_state = ST_NORMAL;
                    end
                    else if (now - window_t0 >= to_ms(on_s))
                    begin
                        // rise over the on window, unreadable ends count as flat
                        if (hum_good && base_rh != '0)
                        begin
                            if (int'(hum) - int'(base_rh) < int'(rise_min))
                            begin
                                count_flat();
                            end
                            else
                            begin
                                flat_run = '0;
                            end
                        end
                        else
                        begin
                            count_flat();
                        end
                        drive = '0;
                        if (flat_run >= flat_lim)
                        begin
                            pol_state = ST_LOCKED;
                        end
                        else
                        begin
                            window_t0 = now;
                            pol_state = ST_PULSE_OFF;
                        end
                    end
                end
                ST_PULSE_OFF:
                begin
                    if (wet)
                    begin
                        pol_state = ST_NORMAL;
                    end
                    else if (now - window_t0 >= to_ms(off_s))
                    begin
                        window_t0 = now;
                        base_rh   = hum_good ? hum : '0;
                        pol_state = ST_PULSE_ON;
                    end
                    else
                    begin
                        drive = '0;
                    end
                end
                ST_LOCKED:
                begin
                    drive = '0;
                end
                default:
                begin
                end
            endcase
        end
        res.drive = drive;
        res.code  = pol_state;
        res.lock  = (pol_state == ST_LOCKED);
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        gated_drive_t want;
        if (!rst_n)
        begin
            reserve_s = RESERVE_SECONDS_RST;
            on_s      = PULSE_ON_SECONDS_RST;
            off_s     = PULSE_OFF_SECONDS_RST;
            rise_min  = RISE_THRESHOLD_RST;
            flat_lim  = FLAT_LIMIT_RST;
            back_to_normal();
            awaited_drives.delete();
            n_err     = 0;
            n_checked = 0;
            n_lock    = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (reg_index_t'(paddr[4:2]))
                    REG_RESERVE_SECONDS:   reserve_s = pwdata[SEC_W-1:0];
                    REG_PULSE_ON_SECONDS:  on_s      = pwdata[SEC_W-1:0];
                    REG_PULSE_OFF_SECONDS: off_s     = pwdata[SEC_W-1:0];
                    REG_RISE_THRESHOLD:    rise_min  = pwdata[RH_W-1:0];
                    REG_FLAT_LIMIT:        flat_lim  = pwdata[FLAT_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
            // result side first: a result never belongs to this edge's input
            if (out_valid && out_ready)
            begin
                if (awaited_drives.size() == 0)
                begin
                    $error("result transfer with no prediction waiting");
                    n_err++;
                end
                else
                begin
                    want = awaited_drives.pop_front();
                    n_checked++;
                    if (want.lock)
                    begin
                        n_lock++;
                    end
                    if (drive_out !== want.drive)
                    begin
                        $error("drive_out: expected %0d, actual %0d", want.drive, drive_out);
                        n_err++;
                    end
                    if (policy_code !== 3'(want.code))
                    begin
                        $error("policy_code: expected %0d, actual %0d",
                               3'(want.code), policy_code);
                        n_err++;
                    end
                    if (locked !== want.lock)
                    begin
                        $error("locked: expected %0d, actual %0d", want.lock, locked);
                        n_err++;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                awaited_drives.push_back(gate_drive(mode, water_present, now_ms,
                                                    requested_drive, humidity,
                                                    humidity_ok));
            end
        end
        pending   <= awaited_drives.size();
        errors    <= n_err;
        checked   <= n_checked;
        lock_hits <= n_lock;
    end

endmodule

// ===== test/humidifier_water_loss_interlock_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// humidifier_water_loss_interlock_tb
// Drives the water-loss interlock with directed water-loss sequences and then
// random dry spells with rising, flat and unreadable humidity under several
// window and lock settings, with random stalls on both channels; the checker
// beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module humidifier_water_loss_interlock_tb;
    import hwli_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int HOLD_CYCLES = 60;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    logic              mode;
    logic              water_present;
    logic [31:0]       now_ms;
    logic [RH_W-1:0]   requested_drive;
    logic [RH_W-1:0]   humidity;
    logic              humidity_ok;
    logic              out_valid;
    logic              out_ready;
    logic [RH_W-1:0]   drive_out;
    logic [2:0]        policy_code;
    logic              locked;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [4:0]        paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    int                pending;
    int                errors;
    int                checked;
    int                lock_hits;

    int                items_sent;
    int                settings_used;
    int                holds_asked;
    bit                tx_idle_on;
    bit                rx_idle_on;
    int                reserve_cfg;
    int                on_cfg;
    int                off_cfg;
    int                rise_cfg;
    logic [31:0]       cur_ms;
    int                hum_level;

    humidifier_water_loss_interlock uut (.*);

    humidifier_water_loss_interlock_checker chk (.*);

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // result side: random stalls, plus long hold-offs on request
    initial
    begin : result_sink
        int holds_done;
        holds_done = 0;
        forever
        begin
            if (holds_done != holds_asked)
            begin
                holds_done = holds_asked;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (rx_idle_on && $urandom_range(0, 3) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge clk);
            end
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
            begin
                quiet = 0;
            end
            else
            begin
                quiet++;
            end
        end
        $display("humidifier_water_loss_interlock_tb NOT OK");
        $finish;
    end

    task automatic send_item(
        input logic            md,
        input logic            wet,
        input logic [31:0]     now,
        input logic [RH_W-1:0] req,
        input logic [RH_W-1:0] hum,
        input logic            hum_ok
    );
        if (tx_idle_on && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        in_valid        <= 1'b1;
        mode            <= md;
        water_present   <= wet;
        now_ms          <= now;
        requested_drive <= req;
        humidity        <= hum;
        humidity_ok     <= hum_ok;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        items_sent++;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input reg_index_t idx, input int value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= 32'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
    endtask

    task automatic set_config(input int res_s, input int on_s, input int off_s,
                              input int rise, input int flat);
        write_reg(REG_RESERVE_SECONDS, res_s);
        write_reg(REG_PULSE_ON_SECONDS, on_s);
        write_reg(REG_PULSE_OFF_SECONDS, off_s);
        write_reg(REG_RISE_THRESHOLD, rise);
        write_reg(REG_FLAT_LIMIT, flat);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        reserve_cfg = res_s;
        on_cfg      = on_s;
        off_cfg     = off_s;
        rise_cfg    = rise;
        settings_used++;
    endtask

    // time step aimed at window boundaries of the current setting
    function automatic int unsigned pick_step();
        int unsigned span;
        case ($urandom_range(0, 7))
            0, 1: span = reserve_cfg;
            2, 3: span = on_cfg;
            4, 5: span = off_cfg;
            default: return $urandom_range(0, 1500);
        endcase
        span = span * 1000;
        case ($urandom_range(0, 3))
            0: return span;
            1: return (span == 0) ? 0 : span - 1;
            default: return $urandom_range(span / 2, span + span / 2 + 1);
        endcase
    endfunction

    task automatic random_items(input int count, input bit with_pressure);
        int              i;
        int              dry_left;
        int              d;
        int              pick;
        logic            md;
        logic            wet;
        logic            ok;
        logic [RH_W-1:0] req;
        logic [RH_W-1:0] hum;
        logic [31:0]     now;
        dry_left = 0;
        cur_ms   = $urandom;
        for (i = 0; i < count; i++)
        begin
            if (with_pressure && i == count / 3)
            begin
                holds_asked++;
            end
            if (with_pressure && i == 2 * count / 3)
            begin
                wait_drained();
            end
            cur_ms = cur_ms + pick_step();
            // dry spells with rare sensor glitches, separated by wet stretches
            if (dry_left > 0)
            begin
                dry_left--;
                wet = ($urandom_range(0, 29) == 0);
            end
            else
            begin
                wet = 1'b1;
                if ($urandom_range(0, 2) == 0)
                begin
                    dry_left = $urandom_range(4, 40);
                end
            end
            d = $urandom_range(0, rise_cfg + 20);
            if ($urandom_range(0, 3) == 0)
            begin
                d = -d / 2;
            end
            hum_level = hum_level + d;
            if (hum_level < 0 || hum_level > 10000)
            begin
                hum_level = $urandom_range(0, 4000);
            end
            hum  = RH_W'(hum_level);
            ok   = 1'b1;
            pick = $urandom_range(0, 99);
            if (pick < 8)
            begin
                ok  = 1'b0;
                hum = RH_W'($urandom_range(0, 16383));
            end
            else if (pick < 13)
            begin
                hum = RH_W'($urandom_range(10001, 16383));
            end
            else if (pick < 16)
            begin
                hum = '0;
            end
            if ($urandom_range(0, 6) == 0)
            begin
                req = RH_W'($urandom_range(0, 16383));
            end
            else
            begin
                req = RH_W'($urandom_range(0, 10000));
            end
            md  = ($urandom_range(0, 24) == 0);
            now = cur_ms;
            // unrelated timestamp and water flag
            if ($urandom_range(0, 39) == 0)
            begin
                now = $urandom;
                wet = 1'($urandom_range(0, 1));
            end
            send_item(md, wet, now, req, hum, ok);
        end
    endtask

    initial
    begin : stimulus
        logic [31:0] t0;
        rst_n           <= 1'b0;
        in_valid        <= 1'b0;
        mode            <= 1'b0;
        water_present   <= 1'b0;
        now_ms          <= '0;
        requested_drive <= '0;
        humidity        <= '0;
        humidity_ok     <= 1'b0;
        psel            <= 1'b0;
        penable         <= 1'b0;
        pwrite          <= 1'b0;
        paddr           <= '0;
        pwdata          <= '0;
        tx_idle_on    = 1'b1;
        rx_idle_on    = 1'b1;
        holds_asked   = 0;
        items_sent    = 0;
        settings_used = 1;
        reserve_cfg   = 600;
        on_cfg        = 60;
        off_cfg       = 120;
        rise_cfg      = 100;
        hum_level     = 3000;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset-value windows, timestamps wrapping inside the sequence
        t0 = 32'hFFFF_FFF0;
        send_item(1'b1, 1'b1, 32'hFFFF_FFFF, 14'h3FFF, 14'h3FFF, 1'b1);
        send_item(1'b0, 1'b1, 32'd0, 14'd10000, 14'd0, 1'b0);
        send_item(1'b0, 1'b0, t0, 14'h3FFF, 14'd5000, 1'b1);
        send_item(1'b0, 1'b0, t0 + 32'd599999, 14'd1234, 14'd5000, 1'b1);
        send_item(1'b0, 1'b0, t0 + 32'd600000, 14'd2000, 14'd5000, 1'b1);
        send_item(1'b0, 1'b0, t0 + 32'd660000, 14'd2000, 14'd5050, 1'b1);
        send_item(1'b0, 1'b0, t0 + 32'd720000, 14'd3000, 14'd5050, 1'b1);
        send_item(1'b0, 1'b0, t0 + 32'd780000, 14'd3000, 14'd10001, 1'b1);
        send_item(1'b0, 1'b0, t0 + 32'd840000, 14'd3000, 14'd6000, 1'b1);
        send_item(1'b0, 1'b0, t0 + 32'd960000, 14'd3000, 14'd4000, 1'b0);
        send_item(1'b0, 1'b0, t0 + 32'd1020000, 14'd3000, 14'd9000, 1'b1);
        send_item(1'b0, 1'b1, t0 + 32'd1030000, 14'd10000, 14'd9000, 1'b1);
        send_item(1'b1, 1'b0, 32'd0, 14'd10000, 14'd0, 1'b0);
        send_item(1'b0, 1'b0, 32'd100, 14'd500, 14'd0, 1'b1);
        send_item(1'b0, 1'b1, 32'd200, 14'd500, 14'd0, 1'b1);
        send_item(1'b0, 1'b0, 32'd1000, 14'd700, 14'd2000, 1'b1);
        send_item(1'b0, 1'b0, 32'd601000, 14'd700, 14'd2000, 1'b1);
        send_item(1'b0, 1'b1, 32'd602000, 14'd700, 14'd2000, 1'b1);
        send_item(1'b0, 1'b0, 32'd700000, 14'd0, 14'd2000, 1'b1);
        send_item(1'b0, 1'b0, 32'd1300000, 14'd0, 14'd2000, 1'b1);
        send_item(1'b0, 1'b0, 32'd1360000, 14'd800, 14'd2100, 1'b1);
        send_item(1'b0, 1'b1, 32'd1370000, 14'd800, 14'd2100, 1'b1);
        wait_drained();

        set_config(2, 1, 1, 100, 3);
        random_items(180, 1'b1);
        wait_drained();

        set_config(0, 0, 0, 0, 0);
        random_items(80, 1'b0);
        wait_drained();

        set_config(65535, 65535, 65535, 10000, 255);
        random_items(80, 1'b0);

        repeat (3)
        begin
            wait_drained();
            set_config($urandom_range(0, 20), $urandom_range(0, 10), $urandom_range(0, 10),
                       $urandom_range(0, 300), $urandom_range(1, 6));
            random_items(110, 1'b0);
        end
        wait_drained();

        // closing stretch at reset values, both sides streaming
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        set_config(600, 60, 120, 100, 3);
        random_items(80, 1'b0);
        wait_drained();

        $display("sent %0d input transfers, checked %0d results over %0d register settings",
                 items_sent, checked, settings_used);
        $display("%0d results were in the locked state", lock_hits);
        if (errors == 0)
        begin
            $display("humidifier_water_loss_interlock_tb OK");
        end
        else
        begin
            $display("humidifier_water_loss_interlock_tb NOT OK");
        end
        $finish;
    end

endmodule
